// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the gain control sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define ASSERT_AR(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent, outside reset.
`define ASSERT_AR_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/sgc_pkg.sv -----
// Package with types, constants and the gain table of the stepped gain control.
package sgc_pkg;

	localparam int CHANNELS_DEF  = 6;
	localparam int MAX_LEVEL_DEF = 18;

	localparam int SAMPLE_W  = 10;
	localparam int CHANNEL_W = 3;
	localparam int SCALED_W  = 16;
	localparam int LEVEL_W   = 5;
	localparam int NUM_W     = 42;
	localparam int DEN_W     = 24;
	localparam int SQ_W      = 20;
	localparam int GAIN_W    = 15;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 18;
	localparam int TARGET_W  = 18;
	localparam int WEIGHT_W  = 16;

	localparam int RESET_COUNT  = 50;
	localparam int TARGET_RST   = 65536;
	localparam int BAND_RST     = 20000;
	localparam int WEIGHT_RST   = 65208;
	localparam int CENTER_RST   = 512;
	localparam int GAIN_ENTRIES = 19;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TARGET,
		CFG_BAND,
		CFG_WEIGHT,
		CFG_CENTER
	} sgc_cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MNH,
		ST_MD,
		ST_MHI,
		ST_MLO,
		ST_MSC,
		ST_FIN
	} sgc_state_t;

	typedef struct packed {
		logic [TARGET_W-1:0]  target;
		logic [TARGET_W-1:0]  band;
		logic [WEIGHT_W-1:0]  weight;
		logic [SAMPLE_W-1:0]  center;
	} sgc_cfg_t;

	typedef struct packed {
		logic [NUM_W-1:0]   num;
		logic [DEN_W-1:0]   den;
		logic [LEVEL_W-1:0] level;
	} sgc_entry_t;

	typedef struct packed {
		logic [SCALED_W-1:0] scaled;
		logic [LEVEL_W-1:0]  level;
		logic                changed;
	} sgc_result_t;

	function automatic logic [GAIN_W-1:0] gain_q8(input logic [LEVEL_W-1:0] level);
		logic [GAIN_W-1:0] g;
		case (level)
			5'd0:    g = 15'd1628;
			5'd1:    g = 15'd1711;
			5'd2:    g = 15'd1800;
			5'd3:    g = 15'd1899;
			5'd4:    g = 15'd1997;
			5'd5:    g = 15'd2129;
			5'd6:    g = 15'd2273;
			5'd7:    g = 15'd2441;
			5'd8:    g = 15'd2620;
			5'd9:    g = 15'd2841;
			5'd10:   g = 15'd3107;
			5'd11:   g = 15'd3397;
			5'd12:   g = 15'd3780;
			5'd13:   g = 15'd4297;
			5'd14:   g = 15'd5036;
			5'd15:   g = 15'd6091;
			5'd16:   g = 15'd7727;
			5'd17:   g = 15'd10729;
			default: g = 15'd16384;
		endcase
		return g;
	endfunction

endpackage

// ----- rtl/core/sgc_state_mem.sv -----
// Per-channel state memory with registered read data and reset-valued unwritten entries.
module sgc_state_mem #(
	parameter int CHANNELS  = sgc_pkg::CHANNELS_DEF,
	parameter int MAX_LEVEL = sgc_pkg::MAX_LEVEL_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rd_en,
	input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] rd_addr,
	output sgc_pkg::sgc_entry_t   rd_entry,
	input  logic                  wr_en,
	input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] wr_addr,
	input  sgc_pkg::sgc_entry_t   wr_entry
);

	localparam logic [sgc_pkg::NUM_W-1:0] RstNum =
		sgc_pkg::NUM_W'(sgc_pkg::RESET_COUNT * sgc_pkg::TARGET_RST) << 16;
	localparam logic [sgc_pkg::DEN_W-1:0] RstDen =
		sgc_pkg::DEN_W'(sgc_pkg::RESET_COUNT) << 16;
	localparam logic [sgc_pkg::LEVEL_W-1:0] RstLevel = sgc_pkg::LEVEL_W'(MAX_LEVEL / 2);

	sgc_pkg::sgc_entry_t mem_q [CHANNELS];
	sgc_pkg::sgc_entry_t rd_data_s1;
	logic [CHANNELS-1:0] vld_q;
	logic                rd_vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_s1 <= vld_q[rd_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_entry;
		end
		if (rd_en) begin
			rd_data_s1 <= mem_q[rd_addr];
		end
	end

	always_comb begin
		if (rd_vld_s1) begin
			rd_entry = rd_data_s1;
		end else begin
			rd_entry.num   = RstNum;
			rd_entry.den   = RstDen;
			rd_entry.level = RstLevel;
		end
	end

endmodule

// ----- rtl/core/sgc_seq.sv -----
// Sequencer and shared-multiplier datapath that read, update and write back channel state.
`include "assert_macros.svh"

module sgc_seq #(
	parameter int CHANNELS  = sgc_pkg::CHANNELS_DEF,
	parameter int MAX_LEVEL = sgc_pkg::MAX_LEVEL_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sgc_pkg::sgc_cfg_t                 cfg,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [sgc_pkg::SAMPLE_W-1:0]      sample,
	input  logic [sgc_pkg::CHANNEL_W-1:0]     channel,
	output logic                              rd_en,
	output logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] rd_addr,
	input  sgc_pkg::sgc_entry_t               rd_entry,
	output logic                              wr_en,
	output logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] wr_addr,
	output sgc_pkg::sgc_entry_t               wr_entry,
	output logic                              res_valid,
	input  logic                              res_ready,
	output sgc_pkg::sgc_result_t              res
);

	localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int PW = sgc_pkg::NUM_W + 1;

	sgc_pkg::sgc_state_t state_q, state_d;

	logic [sgc_pkg::SAMPLE_W-1:0] sample_q;
	logic [AW-1:0]                ch_q;
	logic                         oor_q;
	logic [sgc_pkg::SQ_W-1:0]     sq_q;
	logic [sgc_pkg::NUM_W-1:0]    num_q;
	logic [sgc_pkg::DEN_W-1:0]    den_q;
	logic [sgc_pkg::LEVEL_W-1:0]  lvl_q;
	logic [36:0]                  acc_q;
	logic [sgc_pkg::NUM_W-1:0]    num_new_q;
	logic [sgc_pkg::DEN_W-1:0]    den_new_q;
	logic                         gt_q;
	logic                         lt_q;
	logic [sgc_pkg::SCALED_W-1:0] scaled_q;

	logic                         accept;
	logic                         ch_ok;
	logic [sgc_pkg::SAMPLE_W-1:0] dev;
	logic [23:0]                  mul_a;
	logic [18:0]                  mul_b;
	logic [PW-1:0]                prod;
	logic [18:0]                  hi_thr;
	logic [sgc_pkg::TARGET_W-1:0] lo_thr;
	logic                         lo_ok;
	logic [PW-1:0]                num_sum;
	logic [sgc_pkg::DEN_W:0]      den_sum;
	logic                         step_up;
	logic                         step_dn;
	logic [sgc_pkg::LEVEL_W-1:0]  lvl_new;
	logic [23:0]                  clr_base;

	assign accept = in_valid && in_ready;
	assign ch_ok  = {2'b0, channel} < 5'(CHANNELS);
	assign dev    = (sample >= cfg.center) ? (sample - cfg.center) : (cfg.center - sample);
	assign hi_thr = {1'b0, cfg.target} + {1'b0, cfg.band};
	assign lo_thr = cfg.target - cfg.band;
	assign lo_ok  = cfg.band <= cfg.target;

	always_comb begin
		case (state_q)
			sgc_pkg::ST_LOAD: begin
				mul_a = {3'b0, rd_entry.num[20:0]};
				mul_b = {3'b0, cfg.weight};
			end
			sgc_pkg::ST_MNH: begin
				mul_a = {3'b0, num_q[41:21]};
				mul_b = {3'b0, cfg.weight};
			end
			sgc_pkg::ST_MD: begin
				mul_a = den_q;
				mul_b = {3'b0, cfg.weight};
			end
			sgc_pkg::ST_MHI: begin
				mul_a = den_new_q;
				mul_b = hi_thr;
			end
			sgc_pkg::ST_MLO: begin
				mul_a = den_new_q;
				mul_b = {1'b0, lo_thr};
			end
			sgc_pkg::ST_MSC: begin
				mul_a = {9'b0, sgc_pkg::gain_q8(lvl_q)};
				mul_b = {9'b0, sample_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod    = mul_a * mul_b;
	assign num_sum = {1'b0, prod[36:0], 5'b0} + {6'b0, acc_q};
	assign den_sum = {1'b0, prod[39:16]} + 25'h10000;

	assign step_up  = gt_q && (lvl_q < 5'(MAX_LEVEL));
	assign step_dn  = !step_up && lt_q && (lvl_q != '0);
	assign lvl_new  = step_up ? (lvl_q + 5'd1) : (step_dn ? (lvl_q - 5'd1) : lvl_q);
	assign clr_base = 24'(cfg.target) * 24'(sgc_pkg::RESET_COUNT);

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		rd_en     = 1'b0;
		res_valid = 1'b0;
		wr_en     = 1'b0;
		case (state_q)
			sgc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					rd_en   = ch_ok;
					state_d = ch_ok ? sgc_pkg::ST_LOAD : sgc_pkg::ST_FIN;
				end
			end
			sgc_pkg::ST_LOAD: state_d = sgc_pkg::ST_MNH;
			sgc_pkg::ST_MNH:  state_d = sgc_pkg::ST_MD;
			sgc_pkg::ST_MD:   state_d = sgc_pkg::ST_MHI;
			sgc_pkg::ST_MHI:  state_d = sgc_pkg::ST_MLO;
			sgc_pkg::ST_MLO:  state_d = sgc_pkg::ST_MSC;
			sgc_pkg::ST_MSC:  state_d = sgc_pkg::ST_FIN;
			sgc_pkg::ST_FIN: begin
				res_valid = 1'b1;
				if (res_ready) begin
					wr_en   = !oor_q;
					state_d = sgc_pkg::ST_IDLE;
				end
			end
			default: state_d = sgc_pkg::ST_IDLE;
		endcase
	end

	assign rd_addr = AW'(channel);
	assign wr_addr = ch_q;

	always_comb begin
		if (step_up || step_dn) begin
			wr_entry.num   = {2'b0, clr_base, 16'b0};
			wr_entry.den   = sgc_pkg::DEN_W'(sgc_pkg::RESET_COUNT) << 16;
			wr_entry.level = lvl_new;
		end else begin
			wr_entry.num   = num_new_q;
			wr_entry.den   = den_new_q;
			wr_entry.level = lvl_q;
		end
	end

	always_comb begin
		if (oor_q) begin
			res = '0;
		end else begin
			res.scaled  = scaled_q;
			res.level   = lvl_new;
			res.changed = step_up || step_dn;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sgc_pkg::ST_IDLE;
			oor_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				oor_q <= !ch_ok;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			sgc_pkg::ST_IDLE: begin
				if (accept) begin
					sample_q <= sample;
					ch_q     <= AW'(channel);
					sq_q     <= {10'b0, dev} * {10'b0, dev};
				end
			end
			sgc_pkg::ST_LOAD: begin
				num_q <= rd_entry.num;
				den_q <= rd_entry.den;
				lvl_q <= rd_entry.level;
				acc_q <= {16'b0, prod[36:16]} + {1'b0, sq_q, 16'b0};
			end
			sgc_pkg::ST_MNH: begin
				num_new_q <= num_sum[sgc_pkg::NUM_W] ? '1 : num_sum[sgc_pkg::NUM_W-1:0];
			end
			sgc_pkg::ST_MD: begin
				den_new_q <= den_sum[sgc_pkg::DEN_W] ? '1 : den_sum[sgc_pkg::DEN_W-1:0];
			end
			sgc_pkg::ST_MHI: begin
				gt_q <= {1'b0, num_new_q} > prod;
			end
			sgc_pkg::ST_MLO: begin
				lt_q <= lo_ok && ({1'b0, num_new_q} < prod);
			end
			sgc_pkg::ST_MSC: begin
				scaled_q <= prod[23:8];
			end
			default: begin
			end
		endcase
	end

	`ASSERT_AR(a_wr_level_range, clk, arst_n, wr_en |-> wr_entry.level <= 5'(MAX_LEVEL), "level written beyond maximum")
	`ASSERT_AR_NEXT(a_accept_next, clk, arst_n, accept, state_q == sgc_pkg::ST_LOAD || state_q == sgc_pkg::ST_FIN, "bad state after input transfer")
	`ASSERT_AR(a_change_writes, clk, arst_n, res_valid && res_ready && res.changed |-> wr_en, "level change without write-back")
	`ASSERT_AR(a_den_floor, clk, arst_n, state_q == sgc_pkg::ST_MHI |-> den_new_q[23:16] != 8'd0, "denominator below one")

endmodule

// ----- rtl/core/stepped_gain_control_ema.sv -----
// An input passes the states LOAD, MNH, MD, MHI, MLO, MSC and FIN (just FIN if out of
// range) before its result enters the output register; FIN holds while the register is full.
// New inputs wait until FIN is left; the shared multiplier makes six products per item.
// The next input transfer is taken while a finished result waits in the output register.
// Reset clears the configuration to defaults and marks every channel's state as unwritten,
// so each channel starts from the reset sums and the middle gain level; no clearing pass.
module stepped_gain_control_ema #(
	parameter int CHANNELS  = sgc_pkg::CHANNELS_DEF,
	parameter int MAX_LEVEL = sgc_pkg::MAX_LEVEL_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [sgc_pkg::SAMPLE_W-1:0]       sample,
	input  logic [sgc_pkg::CHANNEL_W-1:0]      channel,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [sgc_pkg::SCALED_W-1:0]       scaled_sample,
	output logic [sgc_pkg::LEVEL_W-1:0]        gain_level,
	output logic                               level_changed,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [sgc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sgc_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	sgc_pkg::sgc_cfg_t    cfg_q;
	sgc_pkg::sgc_entry_t  rd_entry;
	sgc_pkg::sgc_entry_t  wr_entry;
	sgc_pkg::sgc_result_t res;
	sgc_pkg::sgc_result_t out_q;
	logic                 out_valid_q;
	logic                 rd_en;
	logic                 wr_en;
	logic [AW-1:0]        rd_addr;
	logic [AW-1:0]        wr_addr;
	logic                 res_valid;
	logic                 res_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target <= sgc_pkg::TARGET_W'(sgc_pkg::TARGET_RST);
			cfg_q.band   <= sgc_pkg::TARGET_W'(sgc_pkg::BAND_RST);
			cfg_q.weight <= sgc_pkg::WEIGHT_W'(sgc_pkg::WEIGHT_RST);
			cfg_q.center <= sgc_pkg::SAMPLE_W'(sgc_pkg::CENTER_RST);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sgc_pkg::CFG_TARGET: cfg_q.target <= cfg_data;
				sgc_pkg::CFG_BAND:   cfg_q.band   <= cfg_data;
				sgc_pkg::CFG_WEIGHT: cfg_q.weight <= cfg_data[sgc_pkg::WEIGHT_W-1:0];
				sgc_pkg::CFG_CENTER: cfg_q.center <= cfg_data[sgc_pkg::SAMPLE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	sgc_state_mem #(
		.CHANNELS  (CHANNELS),
		.MAX_LEVEL (MAX_LEVEL)
	) u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_entry (rd_entry),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_entry (wr_entry)
	);

	sgc_seq #(
		.CHANNELS  (CHANNELS),
		.MAX_LEVEL (MAX_LEVEL)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample    (sample),
		.channel   (channel),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_entry  (rd_entry),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_entry  (wr_entry),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign scaled_sample = out_q.scaled;
	assign gain_level    = out_q.level;
	assign level_changed = out_q.changed;

endmodule
